// ===== sv/assert_macros.svh =====
// Assertion helpers, clocked on clk and quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion lbl failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion lbl failed");

`endif

// ===== sv/tcc_pkg.sv =====
`default_nettype none
package tcc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int ATAN_ENTRIES = 24;
  localparam int ACC_SHIFT    = 12;

  // Datapath widths
  localparam int VW = 52;   // vectoring x/y
  localparam int RW = 34;   // rotation x/y/z
  localparam int AW = 32;   // inner angle, 2^31 = pi
  localparam int MW = 57;   // magnitude times inverse gain

  localparam logic signed [24:0] INV_GAIN_Q24 = 25'sd10188014;
  localparam logic signed [RW-1:0] INV_GAIN_Q30 = RW'(652032875);

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [AW-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef logic signed [15:0] smp_t;
  typedef logic signed [15:0] ang16_t;

  typedef struct packed {
    smp_t accel_x;
    smp_t accel_y;
    smp_t accel_z;
    smp_t mag_x;
    smp_t mag_y;
    smp_t mag_z;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Round Q4.30 to Q1.15 and clamp.
  function automatic smp_t sat_q15(input logic signed [RW-1:0] v);
    logic signed [RW:0] r;
    r = ((RW+1)'(v) + (RW+1)'(16384)) >>> 15;
    if (r > (RW+1)'(32767)) begin
      return 16'sh7fff;
    end else if (r < -(RW+1)'(32768)) begin
      return 16'sh8000;
    end
    return r[15:0];
  endfunction

  function automatic smp_t take_sample(input smp_t raw);
    logic [SAMPLE_BITS-1:0] low;
    low = raw[SAMPLE_BITS-1:0];
    return 16'($signed(low));
  endfunction

endpackage
`default_nettype wire

// ===== sv/tcc_if.sv =====
`default_nettype none
interface tcc_sensor_if;
  import tcc_pkg::*;
  logic valid;
  logic ready;
  smp_t accel_x;
  smp_t accel_y;
  smp_t accel_z;
  smp_t mag_x;
  smp_t mag_y;
  smp_t mag_z;
  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  output mag_x, output mag_y, output mag_z, input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z,
                input mag_x, input mag_y, input mag_z, output ready);
endinterface

interface tcc_angles_if;
  import tcc_pkg::*;
  logic valid;
  logic ready;
  ang16_t roll_angle;
  ang16_t pitch_angle;
  ang16_t heading_angle;
  modport source (output valid, output roll_angle, output pitch_angle,
                  output heading_angle, input ready);
  modport sink (input valid, input roll_angle, input pitch_angle,
                input heading_angle, output ready);
endinterface
`default_nettype wire

// ===== sv/tcc_front.sv =====
`default_nettype none
module tcc_front import tcc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  tcc_sensor_if.sink sensor,
  input  wire logic  q_full,
  output logic       push,
  output item_t      item
);

  logic  fvalid;
  logic  take;

  assign sensor.ready = !fvalid || !q_full;
  assign take = sensor.valid && sensor.ready;
  assign push = fvalid && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      fvalid <= 1'b0;
    end else if (take) begin
      fvalid <= 1'b1;
    end else if (push) begin
      fvalid <= 1'b0;
    end
  end

  // Keep only the live sample bits of every axis.
  always_ff @(posedge clk) begin
    if (take) begin
      item.accel_x <= take_sample(sensor.accel_x);
      item.accel_y <= take_sample(sensor.accel_y);
      item.accel_z <= take_sample(sensor.accel_z);
      item.mag_x   <= take_sample(sensor.mag_x);
      item.mag_y   <= take_sample(sensor.mag_y);
      item.mag_z   <= take_sample(sensor.mag_z);
    end
  end

endmodule
`default_nettype wire

// ===== sv/tcc_queue.sv =====
`default_nettype none
module tcc_queue import tcc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  push,
  input  wire item_t wdata,
  input  wire logic  pop,
  output item_t      rdata,
  output q_stat_t    stat
);

  item_t          mem [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;

  assign stat.full  = (count == (QAW+1)'(QDEPTH));
  assign stat.empty = (count == '0);
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== sv/tcc_vector.sv =====
`default_nettype none
module tcc_vector import tcc_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [VW-1:0] x_in,
  input  wire logic signed [VW-1:0] y_in,
  output logic signed [VW-1:0]      mag,
  output logic [AW-1:0]             ang
);

  logic signed [VW-1:0] xs [CORDIC_STEPS+1];
  logic signed [VW-1:0] ys [CORDIC_STEPS+1];
  logic [AW-1:0]        zs [CORDIC_STEPS+1];

  // Turn left half-plane vectors by pi.
  always_ff @(posedge clk) begin
    if (en) begin
      if (x_in < 0) begin
        xs[0] <= -x_in;
        ys[0] <= -y_in;
        zs[0] <= 32'h8000_0000;
      end else begin
        xs[0] <= x_in;
        ys[0] <= y_in;
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (ys[i] > 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATAN_TAB[i];
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATAN_TAB[i];
        end
      end
    end
  end

  assign mag = xs[CORDIC_STEPS];
  assign ang = zs[CORDIC_STEPS];

endmodule
`default_nettype wire

// ===== sv/tcc_rotate.sv =====
`default_nettype none
module tcc_rotate import tcc_pkg::*; (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [AW-1:0] ang,
  output smp_t               sin_q,
  output smp_t               cos_q
);

  logic signed [RW-1:0] xs [CORDIC_STEPS+1];
  logic signed [RW-1:0] ys [CORDIC_STEPS+1];
  logic signed [RW-1:0] zs [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= INV_GAIN_Q30;
      ys[0] <= '0;
      zs[0] <= RW'($signed(ang));
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[i] >= 0) begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - RW'(ATAN_TAB[i]);
        end else begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + RW'(ATAN_TAB[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_q <= sat_q15(ys[CORDIC_STEPS]);
      cos_q <= sat_q15(xs[CORDIC_STEPS]);
    end
  end

endmodule
`default_nettype wire

// ===== sv/tcc_back.sv =====
`default_nettype none
module tcc_back import tcc_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire item_t    qdata,
  input  wire q_stat_t  qstat,
  output logic          pop,
  tcc_angles_if.source  angles
);

  localparam int LVEC = CORDIC_STEPS + 1;
  localparam int LROT = CORDIC_STEPS + 2;
  localparam int PM   = LVEC + 1;
  localparam int PR   = PM + LVEC + 1;
  localparam int PB   = PR + LROT;
  localparam int PO   = PB + 4 + LVEC;

  logic          en;
  logic [PO:0]   vld;
  item_t         a;

  assign en  = !(vld[PO] && !angles.ready);
  assign pop = en && !qstat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[PO-1:0], !qstat.empty};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a <= qdata;
    end
  end

  // Tilt magnitudes.
  logic signed [VW-1:0] m1_phi, m1_the;
  logic [AW-1:0]        unused_phi, unused_the;

  tcc_vector u_mag_phi (
    .clk(clk), .en(en),
    .x_in(VW'(a.accel_y) <<< ACC_SHIFT), .y_in(VW'(a.accel_z) <<< ACC_SHIFT),
    .mag(m1_phi), .ang(unused_phi)
  );
  tcc_vector u_mag_the (
    .clk(clk), .en(en),
    .x_in(VW'(a.accel_x) <<< ACC_SHIFT), .y_in(VW'(a.accel_z) <<< ACC_SHIFT),
    .mag(m1_the), .ang(unused_the)
  );

  logic signed [MW-1:0] mg_phi, mg_the;

  always_ff @(posedge clk) begin
    if (en) begin
      mg_phi <= MW'($signed(m1_phi[31:0]) * INV_GAIN_Q24);
      mg_the <= MW'($signed(m1_the[31:0]) * INV_GAIN_Q24);
    end
  end

  // Delay gx, gy to the second vectoring stage.
  smp_t dgx [PM+1];
  smp_t dgy [PM+1];
  assign dgx[0] = a.accel_x;
  assign dgy[0] = a.accel_y;
  for (genvar k = 1; k <= PM; k++) begin : g_dnum
    always_ff @(posedge clk) begin
      if (en) begin
        dgx[k] <= dgx[k-1];
        dgy[k] <= dgy[k-1];
      end
    end
  end

  logic signed [VW-1:0] unused_m2p, unused_m2t;
  logic [AW-1:0]        a_phi, a_the;

  tcc_vector u_ang_phi (
    .clk(clk), .en(en),
    .x_in(VW'(mg_phi >>> 24)), .y_in(VW'(dgx[PM]) <<< ACC_SHIFT),
    .mag(unused_m2p), .ang(a_phi)
  );
  tcc_vector u_ang_the (
    .clk(clk), .en(en),
    .x_in(VW'(mg_the >>> 24)), .y_in(VW'(dgy[PM]) <<< ACC_SHIFT),
    .mag(unused_m2t), .ang(a_the)
  );

  logic [AW-1:0] rnd_phi, rnd_the;
  ang16_t        phi_r [PR:PO-1];
  ang16_t        the_r [PR:PO-1];

  assign rnd_phi = a_phi + AW'(32'h8000);
  assign rnd_the = a_the + AW'(32'h8000);

  always_ff @(posedge clk) begin
    if (en) begin
      phi_r[PR] <= rnd_phi[AW-1:AW-16];
      the_r[PR] <= rnd_the[AW-1:AW-16];
    end
  end

  for (genvar k = PR + 1; k < PO; k++) begin : g_dang
    always_ff @(posedge clk) begin
      if (en) begin
        phi_r[k] <= phi_r[k-1];
        the_r[k] <= the_r[k-1];
      end
    end
  end

  smp_t sp, cp, st, ct;

  tcc_rotate u_rot_phi (
    .clk(clk), .en(en), .ang({phi_r[PR], 16'h0000}), .sin_q(sp), .cos_q(cp)
  );
  tcc_rotate u_rot_the (
    .clk(clk), .en(en), .ang({the_r[PR], 16'h0000}), .sin_q(st), .cos_q(ct)
  );

  // Delay the field sample to the derotation products.
  smp_t dbx [PB+1];
  smp_t dby [PB+1];
  smp_t dbz [PB+1];
  assign dbx[0] = a.mag_x;
  assign dby[0] = a.mag_y;
  assign dbz[0] = a.mag_z;
  for (genvar k = 1; k <= PB; k++) begin : g_db
    always_ff @(posedge clk) begin
      if (en) begin
        dbx[k] <= dbx[k-1];
        dby[k] <= dby[k-1];
        dbz[k] <= dbz[k-1];
      end
    end
  end

  logic signed [31:0] stsp, stcp, bxct, bzsp, bycp;
  smp_t               by_p, bz_p;
  logic signed [47:0] t1, t2, fxa;
  logic signed [32:0] fyd;
  logic signed [48:0] fx, nfy;

  always_ff @(posedge clk) begin
    if (en) begin
      stsp <= st * sp;
      stcp <= st * cp;
      bxct <= dbx[PB] * ct;
      bzsp <= dbz[PB] * sp;
      bycp <= dby[PB] * cp;
      by_p <= dby[PB];
      bz_p <= dbz[PB];
      t1   <= by_p * stsp;
      t2   <= bz_p * stcp;
      fxa  <= 48'(bxct) <<< 15;
      fyd  <= 33'(bzsp) - 33'(bycp);
      fx   <= 49'(fxa) + 49'(t1) + 49'(t2);
      nfy  <= -(49'(fyd) <<< 15);
    end
  end

  logic signed [VW-1:0] unused_m3;
  logic [AW-1:0]        a_psi, rnd_psi;

  tcc_vector u_head (
    .clk(clk), .en(en), .x_in(VW'(fx)), .y_in(VW'(nfy)), .mag(unused_m3), .ang(a_psi)
  );

  assign rnd_psi = a_psi + AW'(32'h8000);

  always_ff @(posedge clk) begin
    if (en) begin
      angles.roll_angle    <= phi_r[PO-1];
      angles.pitch_angle   <= the_r[PO-1];
      angles.heading_angle <= rnd_psi[AW-1:AW-16];
    end
  end

  assign angles.valid = vld[PO];

endmodule
`default_nettype wire

// ===== sv/tilt_compensated_compass_top.sv =====
// Tilt-compensated compass: one accelerometer and one magnetometer sample in,
// roll, pitch and heading out as signed binary angles (32768 = pi).
// sensor: valid/ready transaction with accel_x/y/z and mag_x/y/z.
// angles: valid/ready transaction with roll_angle, pitch_angle, heading_angle.
// Throughput: one transaction per cycle unless the receiver stalls; a new
// sample may enter every cycle while earlier ones move through the CORDIC
// pipelines. A result passes through the front register, the queue, and the
// chain of vectoring, multiply, vectoring, rotation, derotation products and
// a final vectoring stage before it is presented.
// A front register takes samples into a four-entry queue; the back pipeline
// pops the queue whenever it can advance.
// When the receiver stalls, the whole back pipeline holds, the queue fills
// and then ready drops on the sensor channel. Nothing is lost.
// Reset (rst, synchronous) empties the front register, the queue and the
// pipeline valid bits; no result is pending afterwards.
`default_nettype none
`include "assert_macros.svh"
module tilt_compensated_compass_top import tcc_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  tcc_sensor_if.sink   sensor,
  tcc_angles_if.source angles
);

  logic    push;
  logic    pop;
  item_t   fitem;
  item_t   qitem;
  q_stat_t qstat;

  // Accept and clean up the sample.
  tcc_front u_front (
    .clk(clk), .rst(rst), .sensor(sensor), .q_full(qstat.full),
    .push(push), .item(fitem)
  );

  // Decouple acceptance from the pipeline stall.
  tcc_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(fitem), .pop(pop),
    .rdata(qitem), .stat(qstat)
  );

  // Compute the three angles.
  tcc_back u_back (
    .clk(clk), .rst(rst), .qdata(qitem), .qstat(qstat), .pop(pop), .angles(angles)
  );

  `ASSERT_IMPLY(a_no_push_full, push, !qstat.full)
  `ASSERT_IMPLY(a_no_pop_empty, pop, !qstat.empty)
  `ASSERT_IMPLY(a_stall_no_pop, angles.valid && !angles.ready, !pop)

endmodule
`default_nettype wire

// ===== tb/sv/tilt_compensated_compass_checker.sv =====
module tilt_compensated_compass_checker import tcc_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  logic   in_ready,
  input  item_t  in_item,
  input  logic   out_valid,
  input  logic   out_ready,
  input  ang16_t out_roll,
  input  ang16_t out_pitch,
  input  ang16_t out_heading,
  output int     fail_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    ang16_t roll;
    ang16_t pitch;
    ang16_t heading;
  } attitude_t;

  localparam logic [31:0] TURN_HALF = 32'h8000_0000;
  localparam int          TBL_LEN   = 24;
  localparam logic [31:0] ARCTAN [TBL_LEN] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  attitude_t attitude_q[$];

  // Sign-extend the low SAMPLE_BITS bits of a raw field.
  function automatic longint sample_of(input logic [15:0] raw);
    logic [63:0] v;
    v = 64'(raw) & ((64'd1 << SAMPLE_BITS) - 64'd1);
    if (v[SAMPLE_BITS-1]) v = v - (64'd1 << SAMPLE_BITS);
    return longint'(v);
  endfunction

  // Vectoring rotation: angle of (x, y); returns the scaled magnitude.
  function automatic longint vec_angle(input longint xi, input longint yi,
                                       output logic [31:0] ang);
    longint x, y, dx, dy;
    logic [31:0] z;
    x = xi;
    y = yi;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = TURN_HALF;
    end
    for (int i = 0; i < CORDIC_STEPS && i < TBL_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += ARCTAN[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ARCTAN[i];
      end
    end
    ang = z;
    return x;
  endfunction

  function automatic longint to_q15(input longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic void sin_cos(input logic [31:0] a, output longint s,
                                  output longint c);
    longint x, y, z, dx, dy;
    x = 652032875;
    y = 0;
    z = longint'(signed'(a));
    for (int i = 0; i < CORDIC_STEPS && i < TBL_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx;
        y += dy;
        z -= longint'(ARCTAN[i]);
      end else begin
        x += dx;
        y -= dy;
        z += longint'(ARCTAN[i]);
      end
    end
    s = to_q15(y);
    c = to_q15(x);
  endfunction

  function automatic logic [15:0] round16(input logic [31:0] a);
    logic [31:0] t;
    t = a + 32'h8000;
    return t[31:16];
  endfunction

  // Tilt angle of num against the magnitude of (p, q).
  function automatic logic [15:0] tilt_of(input longint num, input longint p,
                                          input longint q);
    logic [31:0] unused, a;
    longint mag;
    mag = vec_angle(p * 4096, q * 4096, unused);
    mag = (mag * 10188014) >>> 24;
    void'(vec_angle(mag, num * 4096, a));
    return round16(a);
  endfunction

  function automatic attitude_t compass_heading(input item_t it);
    longint gx, gy, gz, bx, by, bz, sp, cp, st, ct, fx, fy;
    logic [15:0] phi, theta;
    logic [31:0] psi;
    attitude_t r;
    gx = sample_of(it.accel_x);
    gy = sample_of(it.accel_y);
    gz = sample_of(it.accel_z);
    bx = sample_of(it.mag_x);
    by = sample_of(it.mag_y);
    bz = sample_of(it.mag_z);
    phi = tilt_of(gx, gy, gz);
    theta = tilt_of(gy, gx, gz);
    sin_cos({phi, 16'h0}, sp, cp);
    sin_cos({theta, 16'h0}, st, ct);
    fx = bx * ct * 32768 + by * (st * sp) + bz * (st * cp);
    fy = (bz * sp - by * cp) * 32768;
    void'(vec_angle(fx, -fy, psi));
    r.roll = phi;
    r.pitch = theta;
    r.heading = round16(psi);
    return r;
  endfunction

  assign pending = attitude_q.size();

  always @(posedge clk) begin
    attitude_t got, want;
    if (rst) begin
      fail_count <= 0;
      attitude_q.delete();
    end else begin
      if (in_valid && in_ready) attitude_q.push_back(compass_heading(in_item));
      if (out_valid && out_ready) begin
        got = '{out_roll, out_pitch, out_heading};
        if (attitude_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = attitude_q.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// ===== tb/sv/tilt_compensated_compass_top_tb.sv =====
module tilt_compensated_compass_top_tb;
  import tcc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 20000;
  localparam int DRAIN    = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count, pending;
  int   src_idle_pct = 0;
  int   snk_stall_pct = 0;
  int   quiet_cycles = 0;

  tcc_sensor_if sensor ();
  tcc_angles_if angles ();

  always #6 clk = ~clk;

  tilt_compensated_compass_top dut (.clk(clk), .rst(rst), .sensor(sensor), .angles(angles));

  tilt_compensated_compass_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(sensor.valid), .in_ready(sensor.ready),
    .in_item('{sensor.accel_x, sensor.accel_y, sensor.accel_z,
               sensor.mag_x, sensor.mag_y, sensor.mag_z}),
    .out_valid(angles.valid), .out_ready(angles.ready),
    .out_roll(angles.roll_angle), .out_pitch(angles.pitch_angle),
    .out_heading(angles.heading_angle),
    .fail_count(fail_count), .pending(pending)
  );

  // Drive the sensor side to known values from time zero.
  initial begin
    sensor.valid = 1'b0;
    {sensor.accel_x, sensor.accel_y, sensor.accel_z} = '0;
    {sensor.mag_x, sensor.mag_y, sensor.mag_z} = '0;
    angles.ready = 1'b0;
  end

  // Receiver: stall at random by the current phase's rate.
  always @(posedge clk) begin
    if (rst) angles.ready <= 1'b0;
    else angles.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (sensor.valid && sensor.ready) || (angles.valid && angles.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Send one transaction, idling first at the phase's rate; hold until accepted.
  task automatic send_sample(input item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      sensor.valid <= 1'b0;
      @(posedge clk);
    end
    sensor.valid <= 1'b1;
    {sensor.accel_x, sensor.accel_y, sensor.accel_z} <= {it.accel_x, it.accel_y, it.accel_z};
    {sensor.mag_x, sensor.mag_y, sensor.mag_z} <= {it.mag_x, it.mag_y, it.mag_z};
    do @(posedge clk); while (!sensor.ready);
  endtask

  function automatic smp_t edge_value();
    case ($urandom_range(5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      4: return 16'(signed'($urandom_range(8)) - 4);
      default: return smp_t'($urandom);
    endcase
  endfunction

  // Some plausible attitudes (a strong gravity axis, moderate tilts), some edge values, the rest fully random.
  function automatic item_t random_sample();
    item_t it;
    it = item_t'({$urandom, $urandom, $urandom});
    case ($urandom_range(9))
      0, 1: begin
        it.accel_x = edge_value();
        it.accel_y = edge_value();
        it.mag_z = edge_value();
      end
      2, 3, 4: begin
        it.accel_x = 16'(signed'($urandom_range(8000)) - 4000);
        it.accel_y = 16'(signed'($urandom_range(8000)) - 4000);
        it.accel_z = 16'(signed'($urandom_range(4000)) + 12000);
      end
      default: ;
    endcase
    return it;
  endfunction

  initial begin
    item_t it;
    item_t directed[$];
    int phase_idle[4] = '{0, 59, 0, 31};
    int phase_stall[4] = '{0, 0, 59, 31};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero vector, full-scale corners, negative x (turn by pi),
    // level attitude (cosine of zero), pure axes.
    directed.push_back('0);
    directed.push_back('{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff});
    directed.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000});
    directed.push_back('{16'sh0000, 16'sh0000, 16'sh4000, 16'sh4000, 16'sh0000, 16'sh0000});
    directed.push_back('{16'sh0000, 16'sh0000, 16'sh4000, 16'shc000, 16'sh0000, 16'sh0000});
    directed.push_back('{16'sh0000, 16'sh0000, 16'shc000, 16'sh0000, 16'sh4000, 16'sh0000});
    directed.push_back('{16'sh4000, 16'sh0000, 16'sh0000, 16'sh0000, 16'shc000, 16'sh1000});
    directed.push_back('{16'shc000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000});
    directed.push_back('{16'sh0000, 16'sh4000, 16'sh0000, 16'sh1000, 16'sh1000, 16'sh1000});
    directed.push_back('{16'sh0000, 16'shc000, 16'sh0000, 16'shf000, 16'sh1000, 16'shf000});
    directed.push_back('{16'sh8000, 16'sh7fff, 16'sh0000, 16'shc000, 16'sh0000, 16'sh0000});
    directed.push_back('{16'sh7fff, 16'sh8000, 16'sh0001, 16'sh0000, 16'sh8000, 16'sh7fff});
    directed.push_back('{16'shffff, 16'sh0001, 16'shffff, 16'sh0001, 16'shffff, 16'sh0001});
    directed.push_back('{16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa});
    foreach (directed[i]) send_sample(directed[i]);

    // Random part: four phases of source idling and receiver stalling, then a stretch with neither.
    for (int ph = 0; ph < 5; ph++) begin
      src_idle_pct = phase_idle[ph % 4];
      snk_stall_pct = phase_stall[ph % 4];
      repeat (ph == 4 ? 200 : 210) send_sample(random_sample());
    end
    sensor.valid <= 1'b0;
    snk_stall_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
